// ===== hdl/tcb_pkg.sv =====
// ----------------------------------------------------------------------------
// tcb_pkg
// Shared types, codes and constants of the terminal cell buffer.
// ----------------------------------------------------------------------------
package tcb_pkg;

	localparam int MAX_COLUMNS_DEF = 128;
	localparam int MAX_LINES_DEF   = 64;
	localparam int COLUMNS_RST     = 80;
	localparam int LINES_RST       = 24;

	localparam int CFG_W   = 8;
	localparam int IDX_W   = 1;
	localparam int ACT_W   = 3;
	localparam int CHAR_W  = 21;
	localparam int COLOR_W = 8;
	localparam int MODE_W  = 2;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [IDX_W-1:0] REG_COLUMNS = 1'b0;
	localparam logic [IDX_W-1:0] REG_LINES   = 1'b1;

	localparam logic [ACT_W-1:0] ACT_PUT        = 3'd0;
	localparam logic [ACT_W-1:0] ACT_SET_CURSOR = 3'd1;
	localparam logic [ACT_W-1:0] ACT_ERASE_DISP = 3'd2;
	localparam logic [ACT_W-1:0] ACT_ERASE_LINE = 3'd3;
	localparam logic [ACT_W-1:0] ACT_SCROLL_UP  = 3'd4;
	localparam logic [ACT_W-1:0] ACT_SCROLL_DN  = 3'd5;
	localparam logic [ACT_W-1:0] ACT_SET_ATTR   = 3'd6;
	localparam logic [ACT_W-1:0] ACT_READ_CELL  = 3'd7;

	localparam logic [MODE_W-1:0] MODE_TO_END     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FROM_START = 2'd1;

	localparam logic [CHAR_W-1:0] BLANK_CHAR = 21'h20;

	typedef struct packed {
		logic [CHAR_W-1:0]  ch;
		logic [COLOR_W-1:0] fg;
		logic [COLOR_W-1:0] bg;
		logic               bold;
	} cell_t;

	localparam cell_t SPACE_CELL = '{ch: BLANK_CHAR, fg: '0, bg: '0, bold: 1'b0};

	// Width of one queue entry; front and back lay it out the same way.
	function automatic int entry_width(input int cw, input int lw, input int nw);
		return ACT_W + CHAR_W + cw + lw + 1 + MODE_W + nw + 2 * COLOR_W + 1;
	endfunction

endpackage

// ===== hdl/tcb_ram.sv =====
// ----------------------------------------------------------------------------
// tcb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/tcb_queue.sv =====
// ----------------------------------------------------------------------------
// tcb_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module tcb_queue
	import tcb_pkg::*;
#(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             full,
	output logic             empty
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [PW:0]      cnt_q;

	assign full  = cnt_q == (PW+1)'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign dout  = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/tcb_front.sv =====
// ----------------------------------------------------------------------------
// tcb_front
// Accept requests and classify them: clamp targets, saturate counts.
// ----------------------------------------------------------------------------
module tcb_front
	import tcb_pkg::*;
#(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	parameter int MAX_LINES   = MAX_LINES_DEF,
	localparam int CW  = $clog2(MAX_COLUMNS),
	localparam int LW  = $clog2(MAX_LINES),
	localparam int CNW = $clog2(MAX_COLUMNS + 1),
	localparam int NW  = $clog2(MAX_LINES + 1),
	localparam int EW  = entry_width(CW, LW, NW)
) (
	input  logic [CNW-1:0]     cols,
	input  logic [NW-1:0]      lines,
	input  logic [ACT_W-1:0]   action,
	input  logic [CHAR_W-1:0]  code_point,
	input  logic [CW-1:0]      target_column,
	input  logic [LW-1:0]      target_line,
	input  logic [MODE_W-1:0]  erase_mode,
	input  logic [NW-1:0]      scroll_count,
	input  logic [COLOR_W-1:0] new_foreground,
	input  logic [COLOR_W-1:0] new_background,
	input  logic               new_bold,
	output logic [EW-1:0]      entry
);

	typedef struct packed {
		logic [ACT_W-1:0]   action;
		logic [CHAR_W-1:0]  code;
		logic [CW-1:0]      tcol;
		logic [LW-1:0]      tline;
		logic               rd_ok;
		logic [MODE_W-1:0]  mode;
		logic [NW-1:0]      count;
		logic [COLOR_W-1:0] fg;
		logic [COLOR_W-1:0] bg;
		logic               bold;
	} entry_t;

	entry_t e;
	logic   col_in, line_in;

	always_comb begin
		col_in  = CNW'(target_column) < cols;
		line_in = NW'(target_line) < lines;
		e.action = action;
		e.code   = code_point;
		e.tcol   = col_in ? target_column : CW'(cols - 1'b1);
		e.tline  = line_in ? target_line : LW'(lines - 1'b1);
		e.rd_ok  = col_in && line_in;
		e.mode   = erase_mode;
		e.count  = (scroll_count > lines) ? lines : scroll_count;
		e.fg     = new_foreground;
		e.bg     = new_background;
		e.bold   = new_bold;
	end

	assign entry = e;

endmodule

// ===== hdl/tcb_back.sv =====
// ----------------------------------------------------------------------------
// tcb_back
// Execute commands on the cell store; own cursor, attributes and result.
// ----------------------------------------------------------------------------
module tcb_back
	import tcb_pkg::*;
#(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	parameter int MAX_LINES   = MAX_LINES_DEF,
	localparam int CW    = $clog2(MAX_COLUMNS),
	localparam int LW    = $clog2(MAX_LINES),
	localparam int CNW   = $clog2(MAX_COLUMNS + 1),
	localparam int NW    = $clog2(MAX_LINES + 1),
	localparam int EW    = entry_width(CW, LW, NW),
	localparam int DEPTH = MAX_COLUMNS * MAX_LINES,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [CNW-1:0]     cols,
	input  logic [NW-1:0]      lines,
	input  logic               cfg_changed,
	input  logic [EW-1:0]      head,
	input  logic               q_empty,
	output logic               pop,
	output logic               init_done,
	output logic               out_valid,
	input  logic               out_ready,
	output cell_t              out_cell,
	output logic [CNW-1:0]     out_col,
	output logic [LW-1:0]      out_line
);

	typedef struct packed {
		logic [ACT_W-1:0]   action;
		logic [CHAR_W-1:0]  code;
		logic [CW-1:0]      tcol;
		logic [LW-1:0]      tline;
		logic               rd_ok;
		logic [MODE_W-1:0]  mode;
		logic [NW-1:0]      count;
		logic [COLOR_W-1:0] fg;
		logic [COLOR_W-1:0] bg;
		logic               bold;
	} entry_t;

	localparam logic [2:0] S_INIT   = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_PUT    = 3'd2;
	localparam logic [2:0] S_ERASE  = 3'd3;
	localparam logic [2:0] S_SCR    = 3'd4;
	localparam logic [2:0] S_SCR_WR = 3'd5;
	localparam logic [2:0] S_RD     = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	function automatic logic [AW-1:0] cell_addr(input logic [LW-1:0] r,
		input logic [CW-1:0] c);
		return AW'(r) * AW'(MAX_COLUMNS) + AW'(c);
	endfunction

	entry_t cmd;
	logic [2:0]         state_q;
	logic               init_done_q, clr_cmd_q;
	logic [AW-1:0]      sweep_q;
	logic [CNW-1:0]     cur_col_q;
	logic [LW-1:0]      cur_line_q;
	logic [COLOR_W-1:0] fg_q, bg_q;
	logic               bold_q;
	logic [ACT_W-1:0]   act_q;
	logic [CHAR_W-1:0]  code_q;
	logic [LW-1:0]      row_q, r_end_q;
	logic [CW-1:0]      col_q, c_end_q;
	logic [NW-1:0]      n_q;
	logic               up_q;
	cell_t              res_q;
	logic               out_valid_q;
	cell_t              out_cell_q;
	logic [CNW-1:0]     out_col_q;
	logic [LW-1:0]      out_line_q;

	logic               we;
	logic [AW-1:0]      waddr, raddr;
	cell_t              wdata, rdata;
	logic [CW-1:0]      cols_m1, colc, end_col;
	logic [LW-1:0]      lines_m1, src_row;
	logic               copy, last_row, last_col;

	assign cmd       = entry_t'(head);
	assign init_done = init_done_q;
	assign out_valid = out_valid_q;
	assign out_cell  = out_cell_q;
	assign out_col   = out_col_q;
	assign out_line  = out_line_q;
	assign pop       = (state_q == S_IDLE) && !q_empty;

	always_comb begin
		cols_m1  = CW'(cols - 1'b1);
		lines_m1 = LW'(lines - 1'b1);
		colc     = (cur_col_q >= cols) ? cols_m1 : CW'(cur_col_q);
		end_col  = (row_q == r_end_q) ? c_end_q : cols_m1;
		last_col = col_q == cols_m1;
		if (up_q) begin
			copy     = (NW+1)'(row_q) + (NW+1)'(n_q) < (NW+1)'(lines);
			src_row  = LW'(NW'(row_q) + n_q);
			last_row = row_q == lines_m1;
		end else begin
			copy     = NW'(row_q) >= n_q;
			src_row  = LW'(NW'(row_q) - n_q);
			last_row = row_q == '0;
		end
	end

	// Store port steering
	always_comb begin
		we    = 1'b0;
		waddr = cell_addr(row_q, col_q);
		wdata = SPACE_CELL;
		raddr = cell_addr(cmd.tline, cmd.tcol);
		unique case (state_q)
			S_INIT: begin
				we    = 1'b1;
				waddr = sweep_q;
			end
			S_PUT: begin
				we    = 1'b1;
				waddr = cell_addr(cur_line_q, CW'(cur_col_q));
				wdata = '{ch: code_q, fg: fg_q, bg: bg_q, bold: bold_q};
			end
			S_ERASE: we = 1'b1;
			S_SCR: begin
				we    = !copy;
				raddr = cell_addr(src_row, col_q);
			end
			S_SCR_WR: begin
				we    = 1'b1;
				wdata = rdata;
			end
			default: ;
		endcase
	end

	tcb_ram #(.WIDTH($bits(cell_t)), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			init_done_q <= 1'b0;
			clr_cmd_q   <= 1'b0;
			sweep_q     <= '0;
			cur_col_q   <= '0;
			cur_line_q  <= '0;
			fg_q        <= '0;
			bg_q        <= '0;
			bold_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_changed) begin
				if (cur_col_q >= cols) cur_col_q <= CNW'(cols - 1'b1);
				if (NW'(cur_line_q) >= lines) cur_line_q <= lines_m1;
			end
			unique case (state_q) inside
				S_INIT: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == AW'(DEPTH - 1)) begin
						init_done_q <= 1'b1;
						state_q     <= clr_cmd_q ? S_DONE : S_IDLE;
					end
				end
				S_IDLE: if (!q_empty) begin
					act_q  <= cmd.action;
					code_q <= cmd.code;
					res_q  <= '0;
					col_q  <= '0;
					unique case (cmd.action) inside
						ACT_PUT: begin
							if (cur_col_q >= cols) begin
								cur_col_q <= '0;
								if (cur_line_q == lines_m1) begin
									up_q    <= 1'b1;
									n_q     <= NW'(1);
									row_q   <= '0;
									state_q <= S_SCR;
								end else begin
									cur_line_q <= cur_line_q + 1'b1;
									state_q    <= S_PUT;
								end
							end else begin
								state_q <= S_PUT;
							end
						end
						ACT_SET_CURSOR: begin
							cur_col_q  <= CNW'(cmd.tcol);
							cur_line_q <= cmd.tline;
							state_q    <= S_DONE;
						end
						ACT_ERASE_DISP: begin
							if (cmd.mode == MODE_TO_END) begin
								row_q   <= cur_line_q;
								col_q   <= colc;
								r_end_q <= lines_m1;
								c_end_q <= cols_m1;
								state_q <= S_ERASE;
							end else if (cmd.mode == MODE_FROM_START) begin
								row_q   <= '0;
								r_end_q <= cur_line_q;
								c_end_q <= colc;
								state_q <= S_ERASE;
							end else begin
								cur_col_q  <= '0;
								cur_line_q <= '0;
								sweep_q    <= '0;
								clr_cmd_q  <= 1'b1;
								state_q    <= S_INIT;
							end
						end
						ACT_ERASE_LINE: begin
							row_q   <= cur_line_q;
							r_end_q <= cur_line_q;
							c_end_q <= (cmd.mode == MODE_FROM_START) ? colc : cols_m1;
							if (cmd.mode == MODE_TO_END) col_q <= colc;
							state_q <= S_ERASE;
						end
						ACT_SCROLL_UP, ACT_SCROLL_DN: begin
							up_q    <= cmd.action == ACT_SCROLL_UP;
							n_q     <= cmd.count;
							row_q   <= (cmd.action == ACT_SCROLL_UP) ? '0 : lines_m1;
							state_q <= (cmd.count == '0) ? S_DONE : S_SCR;
						end
						ACT_SET_ATTR: begin
							fg_q    <= cmd.fg;
							bg_q    <= cmd.bg;
							bold_q  <= cmd.bold;
							state_q <= S_DONE;
						end
						ACT_READ_CELL: state_q <= cmd.rd_ok ? S_RD : S_DONE;
						default: state_q <= S_DONE;
					endcase
				end
				S_PUT: begin
					cur_col_q <= cur_col_q + 1'b1;
					state_q   <= S_DONE;
				end
				S_ERASE: begin
					if (col_q == end_col) begin
						col_q <= '0;
						if (row_q == r_end_q) state_q <= S_DONE;
						else row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				S_SCR, S_SCR_WR: begin
					if (state_q == S_SCR && copy) begin
						state_q <= S_SCR_WR;
					end else begin
						state_q <= S_SCR;
						if (last_col) begin
							col_q <= '0;
							if (last_row) begin
								if (act_q == ACT_PUT) begin
									cur_line_q <= lines_m1;
									state_q    <= S_PUT;
								end else begin
									state_q <= S_DONE;
								end
							end else begin
								row_q <= up_q ? row_q + 1'b1 : row_q - 1'b1;
							end
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
				end
				S_RD: begin
					res_q   <= rdata;
					state_q <= S_DONE;
				end
				S_DONE: if (!out_valid_q || out_ready) begin
					out_valid_q <= 1'b1;
					clr_cmd_q   <= 1'b0;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			out_cell_q <= res_q;
			out_col_q  <= cur_col_q;
			out_line_q <= cur_line_q;
		end
	end

endmodule

// ===== hdl/terminal_cell_buffer.sv =====
// ----------------------------------------------------------------------------
// terminal_cell_buffer
// Character-cell screen store of a text-mode terminal: put, cursor, erase,
// scroll, attributes and cell read, one result per request.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  -------   ---------------------  ------------------------------------------
//  config    cfg_we                 cfg_index, cfg_data (write only, no wait)
//  request   in_valid / in_ready    action, code_point, target_*, erase_mode,
//                                   scroll_count, new_* attributes
//  result    out_valid / out_ready  cell_*, cursor_column_now, cursor_line_now
//
// Steps: with the back idle, set cursor, set attributes and misses go from
// request accept straight to the result state; put adds a write state and
// read a read state. Erase blanks the cells in turn; scroll copies each cell
// through a read state and a write state and blanks the rest, over the
// visible area, since the single store port pair handles one cell a cycle.
// A put that wraps on the bottom line pays for a one-line scroll first.
// Reset: a clearing pass blanks all MAX_LINES*MAX_COLUMNS cells with in_ready
// low; a full display erase runs the same pass, but with init_done kept high.
// Stalls: a two-entry queue parts the front from the back, and the result
// register holds a finished result while the next request is taken.
module terminal_cell_buffer
	import tcb_pkg::*;
#(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	parameter int MAX_LINES   = MAX_LINES_DEF,
	localparam int CW  = $clog2(MAX_COLUMNS),
	localparam int LW  = $clog2(MAX_LINES),
	localparam int CNW = $clog2(MAX_COLUMNS + 1),
	localparam int NW  = $clog2(MAX_LINES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [ACT_W-1:0]   action,
	input  logic [CHAR_W-1:0]  code_point,
	input  logic [CW-1:0]      target_column,
	input  logic [LW-1:0]      target_line,
	input  logic [MODE_W-1:0]  erase_mode,
	input  logic [NW-1:0]      scroll_count,
	input  logic [COLOR_W-1:0] new_foreground,
	input  logic [COLOR_W-1:0] new_background,
	input  logic               new_bold,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CHAR_W-1:0]  cell_char,
	output logic [COLOR_W-1:0] cell_foreground,
	output logic [COLOR_W-1:0] cell_background,
	output logic               cell_bold,
	output logic [CNW-1:0]     cursor_column_now,
	output logic [LW-1:0]      cursor_line_now
);

	localparam int EW = entry_width(CW, LW, NW);
	localparam int COLS_RST  = (COLUMNS_RST > MAX_COLUMNS) ? MAX_COLUMNS : COLUMNS_RST;
	localparam int LINES_RST_C = (LINES_RST > MAX_LINES) ? MAX_LINES : LINES_RST;

	logic [CNW-1:0] cols_q;
	logic [NW-1:0]  lines_q;
	logic           cfg_changed_q;
	logic [EW-1:0]  entry, head;
	logic           q_full, q_empty, pop, push, init_done;
	cell_t          out_cell;

	// Configuration: clamp to 1..max (lines use only cfg_data[6:0]), then let the
	// back clamp the cursor on the following cycle against the new size.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q        <= CNW'(COLS_RST);
			lines_q       <= NW'(LINES_RST_C);
			cfg_changed_q <= 1'b0;
		end else begin
			cfg_changed_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_COLUMNS: begin
						cfg_changed_q <= 1'b1;
						if (cfg_data == '0) cols_q <= CNW'(1);
						else if ({1'b0, cfg_data} > 9'(MAX_COLUMNS)) cols_q <= CNW'(MAX_COLUMNS);
						else cols_q <= CNW'(cfg_data);
					end
					REG_LINES: begin
						cfg_changed_q <= 1'b1;
						if (cfg_data[6:0] == '0) lines_q <= NW'(1);
						else if ({1'b0, cfg_data[6:0]} > 8'(MAX_LINES)) lines_q <= NW'(MAX_LINES);
						else lines_q <= NW'(cfg_data[6:0]);
					end
					default: ;
				endcase
			end
		end
	end

	// Take a request whenever the queue has room and the store is cleared.
	assign in_ready = !q_full && init_done;
	assign push     = in_valid && in_ready;

	tcb_front #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_LINES(MAX_LINES)) u_front (
		.cols           (cols_q),
		.lines          (lines_q),
		.action         (action),
		.code_point     (code_point),
		.target_column  (target_column),
		.target_line    (target_line),
		.erase_mode     (erase_mode),
		.scroll_count   (scroll_count),
		.new_foreground (new_foreground),
		.new_background (new_background),
		.new_bold       (new_bold),
		.entry          (entry)
	);

	tcb_queue #(.WIDTH(EW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (entry),
		.pop    (pop),
		.dout   (head),
		.full   (q_full),
		.empty  (q_empty)
	);

	tcb_back #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_LINES(MAX_LINES)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cols        (cols_q),
		.lines       (lines_q),
		.cfg_changed (cfg_changed_q),
		.head        (head),
		.q_empty     (q_empty),
		.pop         (pop),
		.init_done   (init_done),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_cell    (out_cell),
		.out_col     (cursor_column_now),
		.out_line    (cursor_line_now)
	);

	assign cell_char       = out_cell.ch;
	assign cell_foreground = out_cell.fg;
	assign cell_background = out_cell.bg;
	assign cell_bold       = out_cell.bold;

	// The reported cursor never runs past the pending-wrap column.
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cursor_column_now <= cols_q)
		else $error("cursor column beyond screen width");

	// The reported cursor line always sits on a visible line.
	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> NW'(cursor_line_now) < lines_q)
		else $error("cursor line beyond screen height");

	// No request is taken while the store is being cleared after reset.
	a_init_block: assert property (@(posedge clk) disable iff (!arst_n)
		!init_done |-> !in_ready)
		else $error("request taken during clearing pass");

	// The queue is never pushed when full nor popped when empty.
	a_queue_ok: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_full) && !(pop && q_empty))
		else $error("command queue overrun or underrun");

endmodule
